// ----- design/ppb_pkg.sv -----
// shared types, codes and constants of the phosphor persistence buffer
package ppb_pkg;

   localparam int MAX_COLS_DEF = 256;
   localparam int MAX_ROWS_DEF = 256;

   localparam int OP_W       = 3;
   localparam int COORD_W    = 11;
   localparam int LEVEL_W    = 16;
   localparam int CHAN_W     = 8;
   localparam int COLOR_W    = 3 * CHAN_W;
   localparam int FACTOR_W   = 17;
   localparam int SIZE_W     = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [SIZE_W-1:0]   WIDTH_RST  = 9'd256;
   localparam logic [SIZE_W-1:0]   HEIGHT_RST = 9'd256;
   localparam logic [LEVEL_W-1:0]  FLOOR_RST  = 16'd66;
   localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

   typedef enum logic [OP_W-1:0] {
      OP_DECAY        = 3'd0,
      OP_INJECT       = 3'd1,
      OP_INJECT_COLOR = 3'd2,
      OP_READ         = 3'd3,
      OP_CLEAR        = 3'd4
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_FLOOR  = 2'd2
   } csr_idx_type;

   // what the back end has to do with an item
   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_INJECT,
      KIND_INJECT_COLOR,
      KIND_READ,
      KIND_DECAY,
      KIND_CLEAR
   } kind_type;

   typedef struct packed {
      kind_type              kind;
      logic [LEVEL_W-1:0]    level;
      logic [COLOR_W-1:0]    color;
      logic [FACTOR_W-1:0]   factor;
   } cmd_type;

endpackage

// ----- design/ppb_if.sv -----
// request and response channel interfaces
interface ppb_req_if;
   import ppb_pkg::*;
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            op;
   logic signed [COORD_W-1:0]  col;
   logic signed [COORD_W-1:0]  row;
   logic [LEVEL_W-1:0]         level;
   logic [CHAN_W-1:0]          red_in;
   logic [CHAN_W-1:0]          green_in;
   logic [CHAN_W-1:0]          blue_in;
   logic [FACTOR_W-1:0]        decay_factor;

   modport source (output valid, op, col, row, level, red_in, green_in, blue_in,
                   decay_factor, input ready);
   modport sink (input valid, op, col, row, level, red_in, green_in, blue_in,
                 decay_factor, output ready);
endinterface

interface ppb_rsp_if;
   import ppb_pkg::*;
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  level_out;
   logic [CHAN_W-1:0]   red_out;
   logic [CHAN_W-1:0]   green_out;
   logic [CHAN_W-1:0]   blue_out;
   logic                hit;

   modport source (output valid, level_out, red_out, green_out, blue_out, hit,
                   input ready);
   modport sink (input valid, level_out, red_out, green_out, blue_out, hit,
                 output ready);
endinterface

// ----- design/phosphor_persistence_buffer_unit.sv -----
// top level of the phosphor persistence buffer
//
//  channel    dir  handshake        carries
//  req_chan   in   valid / ready    op, col, row, level, rgb, decay_factor
//  rsp_chan   out  valid / ready    level_out, red_out, green_out, blue_out, hit
//  csr_*      in   csr_we           csr_index, csr_wdata (no read-back)
//
// the back end takes a queued item once the result register is empty; a point
// item does a store read, then a write-back, a miss or unknown op loads a result
// with hit low, and clear and decay sweep the whole store; the next item starts
// the cycle after the result is taken, so the back end handles one item at a time
// after reset a clearing pass runs with req_chan.ready low; the 4-entry queue
// keeps accepting until it is full while the back end stalls
module phosphor_persistence_buffer_unit
   import ppb_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   ppb_req_if.sink               req_chan,
   ppb_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CMD_W  = $bits(cmd_type) + ADDR_W;

   logic [SIZE_W-1:0]  width_ff, width_in;
   logic [SIZE_W-1:0]  height_ff, height_in;
   logic [LEVEL_W-1:0] floor_ff, floor_in;

   logic               init_busy;
   logic               q_full;
   logic               q_empty;
   logic               q_push;
   logic               q_pop;
   cmd_type            push_cmd;
   logic [ADDR_W-1:0]  push_addr;
   cmd_type            pop_cmd;
   logic [ADDR_W-1:0]  pop_addr;
   logic [CMD_W-1:0]   pop_data;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      floor_in  = floor_ff;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_WIDTH:  width_in  = csr_wdata[SIZE_W-1:0];
            CSR_HEIGHT: height_in = csr_wdata[SIZE_W-1:0];
            CSR_FLOOR:  floor_in  = csr_wdata[LEVEL_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RST;
         height_ff <= HEIGHT_RST;
         floor_ff  <= FLOOR_RST;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         floor_ff  <= floor_in;
      end
   end

   ppb_front #(
      .MAX_COLS (MAX_COLS),
      .MAX_ROWS (MAX_ROWS),
      .ADDR_W   (ADDR_W)
   ) u_front (
      .req_chan  (req_chan),
      .width     (width_ff),
      .height    (height_ff),
      .init_busy (init_busy),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_cmd     (push_cmd),
      .q_addr    (push_addr)
   );

   ppb_queue #(
      .WIDTH (CMD_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_cmd, push_addr}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (pop_data),
      .empty     (q_empty)
   );

   assign pop_cmd  = cmd_type'(pop_data[CMD_W-1:ADDR_W]);
   assign pop_addr = pop_data[ADDR_W-1:0];

   ppb_back #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .floor_level (floor_ff),
      .q_empty     (q_empty),
      .q_cmd       (pop_cmd),
      .q_addr      (pop_addr),
      .q_pop       (q_pop),
      .init_busy   (init_busy),
      .rsp_chan    (rsp_chan)
   );

`ifndef SYNTH
   // no item enters while the store is being cleared after reset
   a_no_accept_in_init: assert property (@(posedge clock) disable iff (reset)
      init_busy |-> !req_chan.ready)
      else $error("item accepted during clearing pass");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("command queue overflow");

   // a command starts only with the result register empty
   a_pop_slot_free: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !rsp_chan.valid)
      else $error("command started while a result is pending");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("pop from empty queue");
`endif

endmodule

// ----- design/ppb_front.sv -----
// front end: accepts items, checks bounds, forms the address and the command
module ppb_front
   import ppb_pkg::*;
#(
   parameter int MAX_COLS = MAX_COLS_DEF,
   parameter int MAX_ROWS = MAX_ROWS_DEF,
   parameter int ADDR_W   = 16
) (
   ppb_req_if.sink            req_chan,
   input  logic [SIZE_W-1:0]  width,
   input  logic [SIZE_W-1:0]  height,
   input  logic               init_busy,
   input  logic               q_full,
   output logic               q_push,
   output cmd_type            q_cmd,
   output logic [ADDR_W-1:0]  q_addr
);

   localparam int CMP_W = 14;
   localparam logic [CMP_W-1:0] COLS_LIM = CMP_W'(MAX_COLS);
   localparam logic [CMP_W-1:0] ROWS_LIM = CMP_W'(MAX_ROWS);

   logic [CMP_W-1:0] w_eff;
   logic [CMP_W-1:0] h_eff;
   logic             col_ok;
   logic             row_ok;
   logic             in_area;
   logic [31:0]      lin;

   // oversized area acts as the full store
   assign w_eff = (CMP_W'(width) > COLS_LIM) ? COLS_LIM : CMP_W'(width);
   assign h_eff = (CMP_W'(height) > ROWS_LIM) ? ROWS_LIM : CMP_W'(height);

   assign col_ok  = !req_chan.col[COORD_W-1] && (CMP_W'(req_chan.col[COORD_W-2:0]) < w_eff);
   assign row_ok  = !req_chan.row[COORD_W-1] && (CMP_W'(req_chan.row[COORD_W-2:0]) < h_eff);
   assign in_area = col_ok && row_ok;

   assign lin    = 32'(req_chan.row[COORD_W-2:0]) * 32'(MAX_COLS)
                 + 32'(req_chan.col[COORD_W-2:0]);
   assign q_addr = lin[ADDR_W-1:0];

   assign req_chan.ready = !q_full && !init_busy;
   assign q_push         = req_chan.valid && req_chan.ready;

   always_comb begin
      q_cmd.level  = req_chan.level;
      q_cmd.color  = {req_chan.red_in, req_chan.green_in, req_chan.blue_in};
      // factor above one acts as one
      q_cmd.factor = (req_chan.decay_factor > FACTOR_ONE) ? FACTOR_ONE
                                                          : req_chan.decay_factor;
      case (op_type'(req_chan.op))
         OP_DECAY:        q_cmd.kind = KIND_DECAY;
         OP_CLEAR:        q_cmd.kind = KIND_CLEAR;
         OP_INJECT:       q_cmd.kind = in_area ? KIND_INJECT : KIND_NONE;
         OP_INJECT_COLOR: q_cmd.kind = in_area ? KIND_INJECT_COLOR : KIND_NONE;
         OP_READ:         q_cmd.kind = in_area ? KIND_READ : KIND_NONE;
         default:         q_cmd.kind = KIND_NONE;
      endcase
   end

endmodule

// ----- design/ppb_queue.sv -----
// small command queue between front and back end
module ppb_queue
   import ppb_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/ppb_back.sv -----
// back end: pixel stores, point updates, decay and clear sweeps, result register
module ppb_back
   import ppb_pkg::*;
#(
   parameter int DEPTH  = MAX_COLS_DEF * MAX_ROWS_DEF,
   parameter int ADDR_W = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic [LEVEL_W-1:0] floor_level,
   input  logic               q_empty,
   input  cmd_type            q_cmd,
   input  logic [ADDR_W-1:0]  q_addr,
   output logic               q_pop,
   output logic               init_busy,
   ppb_rsp_if.source          rsp_chan
);

   localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(DEPTH - 1);
   localparam int PROD_W = LEVEL_W + FACTOR_W;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_POINT,
      ST_DECAY,
      ST_DECAY_LAST,
      ST_CLEAR
   } state_type;

   logic [LEVEL_W-1:0] level_mem [DEPTH];
   logic [COLOR_W-1:0] color_mem [DEPTH];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  sweep_ff, sweep_in;
   cmd_type            cmd_ff, cmd_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               wb_vld_ff, wb_vld_in;
   logic [ADDR_W-1:0]  wb_addr_ff, wb_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0] rsp_level_ff, rsp_level_in;
   logic [COLOR_W-1:0] rsp_color_ff, rsp_color_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [LEVEL_W-1:0] level_rd_ff;
   logic [COLOR_W-1:0] color_rd_ff;

   logic [ADDR_W-1:0]  rd_addr;
   logic               lvl_we;
   logic [ADDR_W-1:0]  lvl_waddr;
   logic [LEVEL_W-1:0] lvl_wdata;
   logic               col_we;
   logic [ADDR_W-1:0]  col_waddr;
   logic [COLOR_W-1:0] col_wdata;

   logic [PROD_W-1:0]  prod;
   logic [PROD_W-1:0]  rounded;
   logic [LEVEL_W-1:0] sat;
   logic [LEVEL_W-1:0] dec_val;

   // decay of the word read in the previous cycle, rounded to nearest
   assign prod    = PROD_W'(level_rd_ff) * PROD_W'(cmd_ff.factor);
   assign rounded = prod + PROD_W'(32768);
   assign sat     = (rounded[PROD_W-1:LEVEL_W+LEVEL_W] != '0) ? '1
                                                              : rounded[31:16];
   assign dec_val = (sat < floor_level) ? '0 : sat;

   assign init_busy          = (state_ff == ST_INIT);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.level_out = rsp_level_ff;
   assign rsp_chan.red_out   = rsp_color_ff[COLOR_W-1 -: CHAN_W];
   assign rsp_chan.green_out = rsp_color_ff[CHAN_W +: CHAN_W];
   assign rsp_chan.blue_out  = rsp_color_ff[CHAN_W-1:0];
   assign rsp_chan.hit       = rsp_hit_ff;

   always_comb begin
      state_in     = state_ff;
      sweep_in     = sweep_ff;
      cmd_in       = cmd_ff;
      addr_in      = addr_ff;
      wb_vld_in    = 1'b0;
      wb_addr_in   = sweep_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_level_in = rsp_level_ff;
      rsp_color_in = rsp_color_ff;
      rsp_hit_in   = rsp_hit_ff;
      q_pop        = 1'b0;
      rd_addr      = sweep_ff;
      lvl_we       = wb_vld_ff;
      lvl_waddr    = wb_addr_ff;
      lvl_wdata    = dec_val;
      col_we       = 1'b0;
      col_waddr    = addr_ff;
      col_wdata    = cmd_ff.color;

      case (state_ff)
         ST_INIT, ST_CLEAR: begin
            lvl_we    = 1'b1;
            lvl_waddr = sweep_ff;
            lvl_wdata = '0;
            col_we    = 1'b1;
            col_waddr = sweep_ff;
            col_wdata = '0;
            sweep_in  = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_LAST) begin
               sweep_in = '0;
               state_in = ST_IDLE;
               if (state_ff == ST_CLEAR) begin
                  rsp_valid_in = 1'b1;
                  rsp_level_in = '0;
                  rsp_color_in = '0;
                  rsp_hit_in   = 1'b0;
               end
            end
         end
         ST_IDLE: begin
            rd_addr = q_addr;
            // the result register is free until this command loads it
            if (!q_empty && !rsp_valid_ff) begin
               q_pop    = 1'b1;
               cmd_in   = q_cmd;
               addr_in  = q_addr;
               sweep_in = '0;
               case (q_cmd.kind)
                  KIND_INJECT, KIND_INJECT_COLOR, KIND_READ: state_in = ST_POINT;
                  KIND_DECAY: state_in = ST_DECAY;
                  KIND_CLEAR: state_in = ST_CLEAR;
                  default: begin
                     rsp_valid_in = 1'b1;
                     rsp_level_in = '0;
                     rsp_color_in = '0;
                     rsp_hit_in   = 1'b0;
                  end
               endcase
            end
         end
         ST_POINT: begin
            rsp_valid_in = 1'b1;
            rsp_hit_in   = 1'b1;
            rsp_level_in = '0;
            rsp_color_in = '0;
            lvl_waddr    = addr_ff;
            lvl_wdata    = cmd_ff.level;
            state_in     = ST_IDLE;
            case (cmd_ff.kind)
               KIND_INJECT: begin
                  lvl_we = (cmd_ff.level > level_rd_ff);
               end
               KIND_INJECT_COLOR: begin
                  lvl_we = (cmd_ff.level > level_rd_ff);
                  col_we = 1'b1;
               end
               KIND_READ: begin
                  rsp_level_in = level_rd_ff;
                  rsp_color_in = color_rd_ff;
               end
               default: begin
                  rsp_hit_in = 1'b0;
               end
            endcase
         end
         ST_DECAY: begin
            // read one word ahead of the write-back
            wb_vld_in  = 1'b1;
            wb_addr_in = sweep_ff;
            sweep_in   = sweep_ff + ADDR_W'(1);
            if (sweep_ff == ADDR_LAST) begin
               sweep_in = '0;
               state_in = ST_DECAY_LAST;
            end
         end
         ST_DECAY_LAST: begin
            rsp_valid_in = 1'b1;
            rsp_level_in = '0;
            rsp_color_in = '0;
            rsp_hit_in   = 1'b0;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         sweep_ff     <= '0;
         wb_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         wb_vld_ff    <= wb_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      wb_addr_ff   <= wb_addr_in;
      rsp_level_ff <= rsp_level_in;
      rsp_color_ff <= rsp_color_in;
      rsp_hit_ff   <= rsp_hit_in;
   end

   always_ff @(posedge clock) begin
      if (lvl_we) begin
         level_mem[lvl_waddr] <= lvl_wdata;
      end
      level_rd_ff <= level_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (col_we) begin
         color_mem[col_waddr] <= col_wdata;
      end
      color_rd_ff <= color_mem[rd_addr];
   end

endmodule
